// ===== rtl/vbbp_pkg.sv =====
// ----------------------------------------------------------------------------
// vbbp_pkg
// Shared types and constants for the bang-bang valve positioner: field
// widths, ratio constants, state codes and inter-module structs.
// ----------------------------------------------------------------------------
package vbbp_pkg;

   localparam int FRAC_BITS      = 12;
   localparam int ADC_BITS       = 16;
   localparam int COUNT_BITS     = 16;
   localparam int GOAL_BITS      = 13;
   localparam int POS_BITS       = 16;
   localparam int TOL_BITS       = 12;
   localparam int LIMIT_BITS     = 4;
   localparam int KIND_BITS      = 2;
   localparam int CSR_DATA_BITS  = 12;
   localparam int CSR_INDEX_BITS = 2;

   // largest ratio constant (2000) needs 11 bits
   localparam int CONST_BITS = 11;
   localparam int DEN_W      = ADC_BITS + CONST_BITS;
   localparam int MAG_W      = DEN_W + FRAC_BITS;
   localparam int QUO_BITS   = POS_BITS - 1;
   localparam int REM_W      = DEN_W + 1;
   localparam int CMP_W      = DEN_W + QUO_BITS;
   localparam int CNT_W      = $clog2(QUO_BITS + 1);

   // butterfly: 50 w / (47 s); linear: (2000 w - 63 s) / (1400 s)
   localparam int BFLY_NUM_K = 50;
   localparam int BFLY_DEN_K = 47;
   localparam int LIN_W_K    = 2000;
   localparam int LIN_S_K    = 63;
   localparam int LIN_DEN_K  = 1400;

   localparam logic [KIND_BITS-1:0] KIND_BUTTERFLY = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_LINEAR    = 2'd1;

   localparam logic [TOL_BITS-1:0]   START_TOL_RESET   = 12'd205;
   localparam logic [TOL_BITS-1:0]   LOOP_TOL_RESET    = 12'd123;
   localparam logic [LIMIT_BITS-1:0] WRONG_LIMIT_RESET = 4'd5;
   localparam logic [LIMIT_BITS-1:0] WRONG_MAX         = {LIMIT_BITS{1'b1}};

   localparam logic signed [POS_BITS-1:0] POS_MAX       = POS_BITS'((1 << (POS_BITS - 1)) - 1);
   localparam logic signed [POS_BITS-1:0] POS_MINUS_ONE = POS_BITS'(-(1 << FRAC_BITS));

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_LOAD,
      PH_DIV,
      PH_POS,
      PH_FINISH
   } phase_type;

   typedef enum logic [1:0] {
      MODE_IDLE,
      MODE_ARMED,
      MODE_CLOSING,
      MODE_OPENING
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_IDLE,
      STATUS_MOVING,
      STATUS_OK,
      STATUS_FAIL
   } status_type;

   typedef enum logic [1:0] {
      PULSE_NONE,
      PULSE_OPEN,
      PULSE_CLOSE
   } pulse_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_VALVE_KIND,
      CSR_START_TOL,
      CSR_LOOP_TOL,
      CSR_WRONG_LIMIT
   } csr_index_type;

   typedef struct packed {
      logic                done;
      logic                overflow;
      logic [QUO_BITS-1:0] quotient;
      logic                rem_nonzero;
   } div_result_type;

   typedef struct packed {
      pulse_type  pulse;
      logic       channel;
      status_type status;
   } track_result_type;

endpackage

// ===== rtl/valve_bang_bang_positioner.sv =====
// ----------------------------------------------------------------------------
// valve_bang_bang_positioner
// Bang-bang valve positioner: a command item arms a move to a target opening;
// each sample item turns wiper/supply counts into a position and returns the
// next drive pulse and the move status.
//
// Channels: req_* carries items (req_type 0 command, 1 sample), rsp_* returns
// one result per item, csr_* writes the four setup registers (always ready).
// All channels are valid/ready.
// A sample runs the wiper/supply ratio through a bit-serial divider, one
// quotient bit per cycle, and passes through load, divide, position and
// decision steps; a command needs no division and goes from load straight
// to the decision. A new item is taken only once the last one has left the
// decision step.
// The result sits in an output register; while the receiver stalls, one more
// item is taken and worked up to its decision, then the input stalls until
// the output register drains.
// Synchronous reset returns the setup registers to their defaults, clears
// the move state to idle and empties the output register.
// ----------------------------------------------------------------------------
module valve_bang_bang_positioner (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_type,
   input  logic [vbbp_pkg::GOAL_BITS-1:0]        req_target_open,
   input  logic                                  req_valve_select,
   input  logic [vbbp_pkg::COUNT_BITS-1:0]       req_wiper_count,
   input  logic [vbbp_pkg::COUNT_BITS-1:0]       req_supply_count,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [1:0]                            rsp_drive_pulse,
   output logic                                  rsp_drive_channel,
   output logic [1:0]                            rsp_move_status,
   output logic signed [vbbp_pkg::POS_BITS-1:0]  rsp_position_now,
   output logic                                  rsp_divide_fault,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [vbbp_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [vbbp_pkg::CSR_DATA_BITS-1:0]    csr_data
);

   localparam int ADC_BITS   = vbbp_pkg::ADC_BITS;
   localparam int DEN_W      = vbbp_pkg::DEN_W;
   localparam int FRAC_BITS  = vbbp_pkg::FRAC_BITS;
   localparam int POS_BITS   = vbbp_pkg::POS_BITS;
   localparam int GOAL_BITS  = vbbp_pkg::GOAL_BITS;
   localparam int COUNT_BITS = vbbp_pkg::COUNT_BITS;

   // setup registers
   logic [vbbp_pkg::KIND_BITS-1:0]  kind_ff;
   logic [vbbp_pkg::TOL_BITS-1:0]   start_tol_ff;
   logic [vbbp_pkg::TOL_BITS-1:0]   loop_tol_ff;
   logic [vbbp_pkg::LIMIT_BITS-1:0] limit_ff;

   vbbp_pkg::phase_type phase_ff, phase_in;

   logic                         type_ff;
   logic [GOAL_BITS-1:0]         target_ff;
   logic                         select_ff;
   logic [COUNT_BITS-1:0]        wiper_ff;
   logic [COUNT_BITS-1:0]        supply_ff;
   logic                         neg_ff, neg_in;
   logic                         fault_ff, fault_in;
   logic signed [POS_BITS-1:0]   pos_ff, pos_in;

   logic                         rsp_valid_ff;
   logic [1:0]                   pulse_ff;
   logic                         channel_ff;
   logic [1:0]                   status_ff;
   logic signed [POS_BITS-1:0]   out_pos_ff;
   logic                         out_fault_ff;

   logic                         req_fire, div_start, finish_fire;
   logic [ADC_BITS-1:0]          w, s;
   logic [DEN_W-1:0]             wk, sk, bfly, lin_mag, den;
   logic [vbbp_pkg::MAG_W-1:0]   num;
   logic                         lin_neg, is_linear, is_unknown;

   vbbp_pkg::div_result_type     div_res;
   vbbp_pkg::track_result_type   trk_res;

   // ---- setup port ----
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff      <= vbbp_pkg::KIND_BUTTERFLY;
         start_tol_ff <= vbbp_pkg::START_TOL_RESET;
         loop_tol_ff  <= vbbp_pkg::LOOP_TOL_RESET;
         limit_ff     <= vbbp_pkg::WRONG_LIMIT_RESET;
      end else if (csr_valid) begin
         case (vbbp_pkg::csr_index_type'(csr_index))
            vbbp_pkg::CSR_VALVE_KIND:  kind_ff      <= csr_data[vbbp_pkg::KIND_BITS-1:0];
            vbbp_pkg::CSR_START_TOL:   start_tol_ff <= csr_data[vbbp_pkg::TOL_BITS-1:0];
            vbbp_pkg::CSR_LOOP_TOL:    loop_tol_ff  <= csr_data[vbbp_pkg::TOL_BITS-1:0];
            vbbp_pkg::CSR_WRONG_LIMIT: limit_ff     <= csr_data[vbbp_pkg::LIMIT_BITS-1:0];
            default: ;
         endcase
      end
   end

   // ---- sequencer ----
   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         vbbp_pkg::PH_IDLE:   if (req_valid) phase_in = vbbp_pkg::PH_LOAD;
         vbbp_pkg::PH_LOAD:   phase_in = type_ff ? vbbp_pkg::PH_DIV : vbbp_pkg::PH_FINISH;
         vbbp_pkg::PH_DIV:    if (div_res.done) phase_in = vbbp_pkg::PH_POS;
         vbbp_pkg::PH_POS:    phase_in = vbbp_pkg::PH_FINISH;
         vbbp_pkg::PH_FINISH: if (!rsp_valid_ff || rsp_ready) phase_in = vbbp_pkg::PH_IDLE;
         default:             phase_in = vbbp_pkg::PH_IDLE;
      endcase
   end

   always_comb begin
      req_ready   = phase_ff == vbbp_pkg::PH_IDLE;
      div_start   = phase_ff == vbbp_pkg::PH_LOAD && type_ff;
      finish_fire = phase_ff == vbbp_pkg::PH_FINISH && (!rsp_valid_ff || rsp_ready);
   end

   assign req_fire = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= vbbp_pkg::PH_IDLE;
      end else begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         type_ff   <= req_type;
         target_ff <= req_target_open;
         select_ff <= req_valve_select;
         wiper_ff  <= req_wiper_count;
         supply_ff <= req_supply_count;
      end
   end

   // ---- ratio operands ----
   always_comb begin
      w          = wiper_ff[ADC_BITS-1:0];
      s          = supply_ff[ADC_BITS-1:0];
      is_linear  = kind_ff == vbbp_pkg::KIND_LINEAR;
      is_unknown = kind_ff != vbbp_pkg::KIND_BUTTERFLY && !is_linear;
      wk         = DEN_W'(w) * DEN_W'(vbbp_pkg::LIN_W_K);
      sk         = DEN_W'(s) * DEN_W'(vbbp_pkg::LIN_S_K);
      bfly       = DEN_W'(w) * DEN_W'(vbbp_pkg::BFLY_NUM_K);
      lin_neg    = sk > wk;
      lin_mag    = lin_neg ? sk - wk : wk - sk;
      num        = {is_linear ? lin_mag : bfly, {FRAC_BITS{1'b0}}};
      den        = is_linear ? DEN_W'(s) * DEN_W'(vbbp_pkg::LIN_DEN_K)
                             : DEN_W'(s) * DEN_W'(vbbp_pkg::BFLY_DEN_K);
      neg_in     = is_linear && lin_neg;
      fault_in   = !is_unknown && s == '0;
   end

   vbbp_divider u_divider (
      .clock       (clock),
      .reset       (reset),
      .start       (div_start),
      .numerator   (num),
      .denominator (den),
      .result      (div_res)
   );

   // ---- position ----
   always_comb begin
      if (is_unknown) begin
         pos_in = vbbp_pkg::POS_MINUS_ONE;
      end else if (fault_ff || (div_res.overflow && !neg_ff)) begin
         pos_in = vbbp_pkg::POS_MAX;
      end else if (neg_ff) begin
         pos_in = POS_BITS'(0) - ({1'b0, div_res.quotient} + POS_BITS'(div_res.rem_nonzero));
      end else begin
         pos_in = {1'b0, div_res.quotient};
      end
   end

   always_ff @(posedge clock) begin
      if (div_start) begin
         neg_ff   <= neg_in;
         fault_ff <= fault_in;
      end
      if (phase_ff == vbbp_pkg::PH_POS) begin
         pos_ff <= pos_in;
      end
   end

   // ---- move tracking ----
   vbbp_track u_track (
      .clock       (clock),
      .reset       (reset),
      .apply       (finish_fire),
      .is_command  (!type_ff),
      .target      (target_ff),
      .select      (select_ff),
      .position    (pos_ff),
      .start_tol   (start_tol_ff),
      .loop_tol    (loop_tol_ff),
      .wrong_limit (limit_ff),
      .result      (trk_res)
   );

   // ---- result register ----
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (finish_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (finish_fire) begin
         pulse_ff     <= trk_res.pulse;
         channel_ff   <= trk_res.channel;
         status_ff    <= trk_res.status;
         out_pos_ff   <= type_ff ? pos_ff : '0;
         out_fault_ff <= type_ff && fault_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_drive_pulse   = pulse_ff;
   assign rsp_drive_channel = channel_ff;
   assign rsp_move_status   = status_ff;
   assign rsp_position_now  = out_pos_ff;
   assign rsp_divide_fault  = out_fault_ff;

endmodule

// ===== rtl/vbbp_divider.sv =====
// ----------------------------------------------------------------------------
// vbbp_divider
// Restoring divider, one quotient bit per cycle. Flags quotients that do not
// fit the positive position range and reports a nonzero remainder.
// ----------------------------------------------------------------------------
module vbbp_divider (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [vbbp_pkg::MAG_W-1:0]  numerator,
   input  logic [vbbp_pkg::DEN_W-1:0]  denominator,
   output vbbp_pkg::div_result_type    result
);

   localparam int DEN_W    = vbbp_pkg::DEN_W;
   localparam int REM_W    = vbbp_pkg::REM_W;
   localparam int QUO_BITS = vbbp_pkg::QUO_BITS;
   localparam int CMP_W    = vbbp_pkg::CMP_W;
   localparam int CNT_W    = vbbp_pkg::CNT_W;

   logic [REM_W-1:0]    rem_ff, rem_in;
   logic [QUO_BITS-1:0] shift_ff, shift_in;
   logic [DEN_W-1:0]    den_ff, den_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic                ovf_ff, ovf_in;

   logic [REM_W-1:0] trial;
   logic [REM_W-1:0] den_ext;
   logic             fits;

   always_comb begin
      trial    = {rem_ff[REM_W-2:0], shift_ff[QUO_BITS-1]};
      den_ext  = {1'b0, den_ff};
      fits     = trial >= den_ext;
      rem_in   = rem_ff;
      shift_in = shift_ff;
      den_in   = den_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      ovf_in   = ovf_ff;
      done_in  = 1'b0;
      if (start) begin
         den_in   = denominator;
         rem_in   = REM_W'(numerator >> QUO_BITS);
         shift_in = numerator[QUO_BITS-1:0];
         ovf_in   = CMP_W'(numerator) >= {denominator, {QUO_BITS{1'b0}}};
         count_in = CNT_W'(QUO_BITS);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = trial - den_ext;
         end else begin
            rem_in = trial;
         end
         shift_in = {shift_ff[QUO_BITS-2:0], fits};
         count_in = count_ff - CNT_W'(1);
         if (count_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      shift_ff <= shift_in;
      den_ff   <= den_in;
      ovf_ff   <= ovf_in;
   end

   assign result.done        = done_ff;
   assign result.overflow    = ovf_ff;
   assign result.quotient    = shift_ff;
   assign result.rem_nonzero = |rem_ff;

endmodule

// ===== rtl/vbbp_track.sv =====
// ----------------------------------------------------------------------------
// vbbp_track
// Move tracking: holds goal, channel, mode, last driven position and the
// wrong-direction count, and decides pulse and status for each item.
// ----------------------------------------------------------------------------
module vbbp_track (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 apply,
   input  logic                                 is_command,
   input  logic [vbbp_pkg::GOAL_BITS-1:0]       target,
   input  logic                                 select,
   input  logic signed [vbbp_pkg::POS_BITS-1:0] position,
   input  logic [vbbp_pkg::TOL_BITS-1:0]        start_tol,
   input  logic [vbbp_pkg::TOL_BITS-1:0]        loop_tol,
   input  logic [vbbp_pkg::LIMIT_BITS-1:0]      wrong_limit,
   output vbbp_pkg::track_result_type           result
);

   localparam int POS_BITS   = vbbp_pkg::POS_BITS;
   localparam int GOAL_BITS  = vbbp_pkg::GOAL_BITS;
   localparam int TOL_BITS   = vbbp_pkg::TOL_BITS;
   localparam int LIMIT_BITS = vbbp_pkg::LIMIT_BITS;

   vbbp_pkg::mode_type                  mode_ff, mode_in;
   logic [GOAL_BITS-1:0]                goal_ff, goal_in;
   logic                                channel_ff, channel_in;
   logic signed [POS_BITS-1:0]          prev_ff, prev_in;
   logic [LIMIT_BITS-1:0]               wrong_ff, wrong_in;

   logic signed [POS_BITS:0] diff;
   logic [POS_BITS:0]        distance;
   logic [POS_BITS:0]        start_ext, loop_ext;
   logic [POS_BITS-1:0]      abs_p, abs_prev, goal_ext;
   logic                     p_gt_g, p_eq_g, closing, wrong, settle, settle_close;
   logic [LIMIT_BITS-1:0]    wrong_next;

   always_comb begin
      diff      = {position[POS_BITS-1], position} - $signed({1'b0, (POS_BITS-GOAL_BITS)'(0),
                                                              goal_ff});
      distance  = diff[POS_BITS] ? (POS_BITS+1)'(0) - diff : diff;
      start_ext = {(POS_BITS+1-TOL_BITS)'(0), start_tol};
      loop_ext  = {(POS_BITS+1-TOL_BITS)'(0), loop_tol};
      goal_ext  = {(POS_BITS-GOAL_BITS)'(0), goal_ff};
      abs_p     = position[POS_BITS-1] ? POS_BITS'(0) - position : position;
      abs_prev  = prev_ff[POS_BITS-1] ? POS_BITS'(0) - prev_ff : prev_ff;
      p_eq_g    = diff == '0;
      p_gt_g    = !diff[POS_BITS] && !p_eq_g;
      closing   = mode_ff == vbbp_pkg::MODE_CLOSING;
      wrong     = closing ? (abs_p > abs_prev) : (abs_p < abs_prev);
      if (wrong && wrong_ff != vbbp_pkg::WRONG_MAX) begin
         wrong_next = wrong_ff + LIMIT_BITS'(1);
      end else begin
         wrong_next = wrong_ff;
      end
   end

   always_comb begin
      mode_in        = mode_ff;
      goal_in        = goal_ff;
      channel_in     = channel_ff;
      prev_in        = prev_ff;
      wrong_in       = wrong_ff;
      result.pulse   = vbbp_pkg::PULSE_NONE;
      result.status  = vbbp_pkg::STATUS_IDLE;
      settle         = 1'b0;
      settle_close   = closing;
      if (is_command) begin
         goal_in       = target;
         channel_in    = select;
         mode_in       = vbbp_pkg::MODE_ARMED;
         wrong_in      = '0;
         prev_in       = '0;
         result.status = vbbp_pkg::STATUS_MOVING;
      end else begin
         case (mode_ff)
            vbbp_pkg::MODE_IDLE: begin
               result.status = vbbp_pkg::STATUS_IDLE;
            end
            vbbp_pkg::MODE_ARMED: begin
               if (distance < start_ext || p_eq_g) begin
                  result.status = vbbp_pkg::STATUS_OK;
                  mode_in       = vbbp_pkg::MODE_IDLE;
               end else begin
                  mode_in      = p_gt_g ? vbbp_pkg::MODE_CLOSING : vbbp_pkg::MODE_OPENING;
                  settle_close = p_gt_g;
                  settle       = 1'b1;
               end
            end
            default: begin
               wrong_in = wrong_next;
               if (wrong_next > wrong_limit) begin
                  result.status = vbbp_pkg::STATUS_FAIL;
                  mode_in       = vbbp_pkg::MODE_IDLE;
               end else if (closing ? (abs_p < goal_ext) : (abs_p > goal_ext)) begin
                  result.status = vbbp_pkg::STATUS_OK;
                  mode_in       = vbbp_pkg::MODE_IDLE;
               end else begin
                  settle = 1'b1;
               end
            end
         endcase
         if (settle) begin
            if (distance > loop_ext) begin
               prev_in       = position;
               result.pulse  = settle_close ? vbbp_pkg::PULSE_CLOSE : vbbp_pkg::PULSE_OPEN;
               result.status = vbbp_pkg::STATUS_MOVING;
            end else begin
               result.status = (distance > start_ext) ? vbbp_pkg::STATUS_FAIL
                                                      : vbbp_pkg::STATUS_OK;
               mode_in       = vbbp_pkg::MODE_IDLE;
            end
         end
      end
      result.channel = channel_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= vbbp_pkg::MODE_IDLE;
         goal_ff    <= '0;
         channel_ff <= 1'b0;
         prev_ff    <= '0;
         wrong_ff   <= '0;
      end else if (apply) begin
         mode_ff    <= mode_in;
         goal_ff    <= goal_in;
         channel_ff <= channel_in;
         prev_ff    <= prev_in;
         wrong_ff   <= wrong_in;
      end
   end

endmodule

// ===== bench/tb_valve_bang_bang_positioner.sv =====
// ----------------------------------------------------------------------------
// tb_valve_bang_bang_positioner
// Self-checking bench for the bang-bang valve positioner. A short directed
// table hits saturation, zero supply, every valve kind, exact match, wrong
// moves and band corner cases; random phases follow with move sequences,
// noise and stray samples under several setup and idling mixes. Every
// response is checked in order against a pinned value or an in-bench tracking model.
// ----------------------------------------------------------------------------
module tb_valve_bang_bang_positioner;
   timeunit 1ns;
   timeprecision 1ps;

   import vbbp_pkg::*;

   localparam int WATCHDOG_CYCLES = 3000;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int SETTLE_CYCLES   = 30;
   localparam int PHASE_ITEMS     = 154;
   localparam int PHASE_COUNT     = 8;
   localparam int REPORT_LIMIT    = 10;

   typedef struct {
      logic                  is_sample;
      logic [GOAL_BITS-1:0]  target;
      logic                  select;
      logic [COUNT_BITS-1:0] wiper;
      logic [COUNT_BITS-1:0] supply;
   } valve_item_t;

   typedef struct {
      pulse_type                  pulse;
      logic                       channel;
      status_type                 status;
      logic signed [POS_BITS-1:0] position;
      logic                       fault;
   } valve_resp_t;

   typedef enum {ROW_ITEM, ROW_CSR} row_kind_t;

   typedef struct {
      row_kind_t                kind;
      csr_index_type            csr_sel;
      logic [CSR_DATA_BITS-1:0] csr_value;
      valve_item_t              item;
      bit                       pinned;
      valve_resp_t              want;
   } directed_row_t;

   logic                          clock;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic                          req_type = 1'b0;
   logic [GOAL_BITS-1:0]          req_target_open = '0;
   logic                          req_valve_select = 1'b0;
   logic [COUNT_BITS-1:0]         req_wiper_count = '0;
   logic [COUNT_BITS-1:0]         req_supply_count = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic [1:0]                    rsp_drive_pulse;
   logic                          rsp_drive_channel;
   logic [1:0]                    rsp_move_status;
   logic signed [POS_BITS-1:0]    rsp_position_now;
   logic                          rsp_divide_fault;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [CSR_INDEX_BITS-1:0]     csr_index = '0;
   logic [CSR_DATA_BITS-1:0]      csr_data = '0;

   // tracking model state
   logic [KIND_BITS-1:0] cfg_kind = KIND_BUTTERFLY;
   int                   cfg_start_tol = int'(START_TOL_RESET);
   int                   cfg_loop_tol = int'(LOOP_TOL_RESET);
   int                   cfg_wrong_limit = int'(WRONG_LIMIT_RESET);
   mode_type             valve_mode = MODE_IDLE;
   int                   goal_open = 0;
   logic                 goal_channel = 1'b0;
   int                   last_position = 0;
   int                   wrong_count = 0;

   valve_resp_t pending_responses[$];
   valve_resp_t free_resp;
   int          mismatch_count = 0;
   int          items_offered = 0;
   int          req_gap_pct = 0;
   int          rsp_stall_pct = 0;
   int          holds_asked = 0;
   int          holds_served = 0;
   int          hold_left = 0;
   int          quiet_cycles = 0;

   valve_bang_bang_positioner u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_type          (req_type),
      .req_target_open   (req_target_open),
      .req_valve_select  (req_valve_select),
      .req_wiper_count   (req_wiper_count),
      .req_supply_count  (req_supply_count),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_drive_pulse   (rsp_drive_pulse),
      .rsp_drive_channel (rsp_drive_channel),
      .rsp_move_status   (rsp_move_status),
      .rsp_position_now  (rsp_position_now),
      .rsp_divide_fault  (rsp_divide_fault),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic int wiper_position(input logic [COUNT_BITS-1:0] w,
                                         input logic [COUNT_BITS-1:0] s,
                                         output logic fault);
      longint num;
      longint den;
      longint q;
      fault = 1'b0;
      if (cfg_kind > KIND_LINEAR) return -(1 << FRAC_BITS);
      if (s == 0) begin
         fault = 1'b1;
         return 32767;
      end
      if (cfg_kind == KIND_BUTTERFLY) begin
         num = (longint'(1) << FRAC_BITS) * 50 * longint'(w);
         den = 47 * longint'(s);
      end else begin
         num = (longint'(1) << FRAC_BITS) * (2000 * longint'(w) - 63 * longint'(s));
         den = 1400 * longint'(s);
      end
      // round toward minus infinity
      q = (num >= 0) ? num / den : -((-num + den - 1) / den);
      if (q > 32767) q = 32767;
      else if (q < -32768) q = -32768;
      return int'(q);
   endfunction

   function automatic valve_resp_t next_valve_response(input valve_item_t it);
      valve_resp_t r;
      int          pos;
      int          distance;
      int          mag;
      int          prev_mag;
      logic        fault;
      bit          settle;
      bit          closing;
      bit          wrong;
      r.pulse    = PULSE_NONE;
      r.status   = STATUS_IDLE;
      r.position = '0;
      r.fault    = 1'b0;
      if (!it.is_sample) begin
         goal_open     = int'(it.target);
         goal_channel  = it.select;
         valve_mode    = MODE_ARMED;
         wrong_count   = 0;
         last_position = 0;
         r.status      = STATUS_MOVING;
      end else begin
         pos      = wiper_position(it.wiper, it.supply, fault);
         distance = (pos > goal_open) ? pos - goal_open : goal_open - pos;
         mag      = (pos < 0) ? -pos : pos;
         prev_mag = (last_position < 0) ? -last_position : last_position;
         settle   = 1'b0;
         if (valve_mode == MODE_ARMED) begin
            if (distance < cfg_start_tol || pos == goal_open) begin
               r.status   = STATUS_OK;
               valve_mode = MODE_IDLE;
            end else begin
               valve_mode = (pos > goal_open) ? MODE_CLOSING : MODE_OPENING;
               settle     = 1'b1;
            end
         end else if (valve_mode != MODE_IDLE) begin
            closing = (valve_mode == MODE_CLOSING);
            wrong   = closing ? (mag > prev_mag) : (mag < prev_mag);
            if (wrong && wrong_count < 15) wrong_count++;
            if (wrong_count > cfg_wrong_limit) begin
               r.status   = STATUS_FAIL;
               valve_mode = MODE_IDLE;
            end else if (closing ? (mag < goal_open) : (mag > goal_open)) begin
               r.status   = STATUS_OK;
               valve_mode = MODE_IDLE;
            end else begin
               settle = 1'b1;
            end
         end
         if (settle) begin
            if (distance > cfg_loop_tol) begin
               last_position = pos;
               r.pulse       = (valve_mode == MODE_CLOSING) ? PULSE_CLOSE : PULSE_OPEN;
               r.status      = STATUS_MOVING;
            end else begin
               r.status   = (distance > cfg_start_tol) ? STATUS_FAIL : STATUS_OK;
               valve_mode = MODE_IDLE;
            end
         end
         r.position = POS_BITS'(pos);
         r.fault    = fault;
      end
      r.channel = goal_channel;
      return r;
   endfunction

   function automatic valve_item_t move_command(input int target, input logic sel);
      valve_item_t it;
      it.is_sample = 1'b0;
      it.target    = GOAL_BITS'(target);
      it.select    = sel;
      it.wiper     = COUNT_BITS'($urandom);
      it.supply    = COUNT_BITS'($urandom);
      return it;
   endfunction

   function automatic valve_item_t adc_sample(input int w, input int s);
      valve_item_t it;
      it.is_sample = 1'b1;
      it.target    = GOAL_BITS'($urandom);
      it.select    = 1'($urandom);
      it.wiper     = COUNT_BITS'(w);
      it.supply    = COUNT_BITS'(s);
      return it;
   endfunction

   // counts that land near a wanted position for the current valve kind
   function automatic valve_item_t sample_at(input int pos);
      longint s;
      longint w;
      s = $urandom_range(65535, 6000);
      if (cfg_kind == KIND_BUTTERFLY)
         w = (pos < 0) ? 0 : longint'(pos) * 47 * s / 204800;
      else if (cfg_kind == KIND_LINEAR)
         w = (longint'(pos) * 1400 * s / 4096 + 63 * s) / 2000;
      else
         w = $urandom_range(65535);
      if (w < 0) w = 0;
      if (w > 65535) w = 65535;
      if ($urandom_range(99) < 3) s = 0;
      return adc_sample(int'(w), int'(s));
   endfunction

   function automatic directed_row_t item_row(input valve_item_t it);
      directed_row_t row;
      row.kind   = ROW_ITEM;
      row.item   = it;
      row.pinned = 1'b0;
      return row;
   endfunction

   function automatic directed_row_t pinned_row(input valve_item_t it, input pulse_type pulse,
                                                input logic ch, input status_type st,
                                                input int pos, input logic fault);
      directed_row_t row;
      row.kind          = ROW_ITEM;
      row.item          = it;
      row.pinned        = 1'b1;
      row.want.pulse    = pulse;
      row.want.channel  = ch;
      row.want.status   = st;
      row.want.position = POS_BITS'(pos);
      row.want.fault    = fault;
      return row;
   endfunction

   function automatic directed_row_t csr_row(input csr_index_type sel, input int value);
      directed_row_t row;
      row.kind      = ROW_CSR;
      row.csr_sel   = sel;
      row.csr_value = CSR_DATA_BITS'(value);
      return row;
   endfunction

   task automatic offer_item(input valve_item_t it, input bit pinned, input valve_resp_t want);
      valve_resp_t predicted;
      while (req_gap_pct != 0 && $urandom_range(99) < req_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_type         <= it.is_sample;
      req_target_open  <= it.target;
      req_valve_select <= it.select;
      req_wiper_count  <= it.wiper;
      req_supply_count <= it.supply;
      do @(posedge clock); while (!req_ready);
      predicted = next_valve_response(it);
      pending_responses.push_back(pinned ? want : predicted);
      items_offered++;
   endtask

   task automatic write_register(input csr_index_type sel,
                                 input logic [CSR_DATA_BITS-1:0] value, input bit last);
      csr_valid <= 1'b1;
      csr_index <= sel;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      if (last) csr_valid <= 1'b0;
      case (sel)
         CSR_VALVE_KIND:  cfg_kind = value[KIND_BITS-1:0];
         CSR_START_TOL:   cfg_start_tol = int'(value);
         CSR_LOOP_TOL:    cfg_loop_tol = int'(value);
         CSR_WRONG_LIMIT: cfg_wrong_limit = int'(value[LIMIT_BITS-1:0]);
         default: ;
      endcase
   endtask

   task automatic apply_setup(input int kind, input int start_tol, input int loop_tol,
                              input int limit);
      write_register(CSR_VALVE_KIND, CSR_DATA_BITS'(kind), 1'b0);
      write_register(CSR_START_TOL, CSR_DATA_BITS'(start_tol), 1'b0);
      write_register(CSR_LOOP_TOL, CSR_DATA_BITS'(loop_tol), 1'b0);
      write_register(CSR_WRONG_LIMIT, CSR_DATA_BITS'(limit), 1'b1);
   endtask

   task automatic settle_block();
      req_valid <= 1'b0;
      while (pending_responses.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // response side: random stalls plus one long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left--;
      end else if (holds_served != holds_asked) begin
         holds_served = holds_asked;
         hold_left    = HOLD_OFF_CYCLES;
         rsp_ready   <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin : check_responses
      valve_resp_t want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_responses.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("unexpected response: pulse %0d ch %0d status %0d pos %0d fault %0d",
                        rsp_drive_pulse, rsp_drive_channel, rsp_move_status,
                        rsp_position_now, rsp_divide_fault);
         end else begin
            want = pending_responses.pop_front();
            if (rsp_drive_pulse !== want.pulse || rsp_drive_channel !== want.channel ||
                rsp_move_status !== want.status || rsp_position_now !== want.position ||
                rsp_divide_fault !== want.fault) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display({"response mismatch: want pulse %0d ch %0d status %0d pos %0d ",
                            "fault %0d, got pulse %0d ch %0d status %0d pos %0d fault %0d"},
                           want.pulse, want.channel, want.status, want.position, want.fault,
                           rsp_drive_pulse, rsp_drive_channel, rsp_move_status,
                           rsp_position_now, rsp_divide_fault);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_CYCLES) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      directed_row_t directed[$];
      valve_item_t   junk;
      int            phase_end;
      int            roll;
      int            target;
      int            pos;
      int            gap;
      int            stride;

      // idle samples after reset
      directed.push_back(pinned_row(adc_sample(0, 0), PULSE_NONE, 1'b0, STATUS_IDLE,
                                    32767, 1'b1));
      directed.push_back(pinned_row(adc_sample(65535, 1), PULSE_NONE, 1'b0, STATUS_IDLE,
                                    32767, 1'b0));
      // opening move that settles inside the loop band
      directed.push_back(pinned_row(move_command(4096, 1'b1), PULSE_NONE, 1'b1,
                                    STATUS_MOVING, 0, 1'b0));
      directed.push_back(item_row(adc_sample(0, 65535)));
      directed.push_back(item_row(adc_sample(30000, 65535)));
      directed.push_back(item_row(adc_sample(60000, 65535)));
      // goal above full scale, overshoot by zero supply
      directed.push_back(pinned_row(move_command(8191, 1'b0), PULSE_NONE, 1'b0,
                                    STATUS_MOVING, 0, 1'b0));
      directed.push_back(item_row(adc_sample(65535, 65535)));
      directed.push_back(item_row(adc_sample(65535, 0)));
      // closing move with a wrong-direction step
      directed.push_back(pinned_row(move_command(0, 1'b1), PULSE_NONE, 1'b1,
                                    STATUS_MOVING, 0, 1'b0));
      directed.push_back(item_row(adc_sample(30000, 65535)));
      directed.push_back(item_row(adc_sample(65535, 65535)));
      // linear, zero start band, zero wrong-move limit
      directed.push_back(csr_row(CSR_VALVE_KIND, KIND_LINEAR));
      directed.push_back(csr_row(CSR_START_TOL, 0));
      directed.push_back(csr_row(CSR_WRONG_LIMIT, 0));
      directed.push_back(pinned_row(move_command(0, 1'b1), PULSE_NONE, 1'b1,
                                    STATUS_MOVING, 0, 1'b0));
      directed.push_back(item_row(adc_sample(63, 2000)));
      directed.push_back(pinned_row(move_command(4096, 1'b0), PULSE_NONE, 1'b0,
                                    STATUS_MOVING, 0, 1'b0));
      directed.push_back(item_row(adc_sample(0, 65535)));
      directed.push_back(item_row(adc_sample(63, 2000)));
      // unknown kind ignores zero supply
      directed.push_back(csr_row(CSR_VALVE_KIND, 3));
      directed.push_back(csr_row(CSR_START_TOL, 100));
      directed.push_back(csr_row(CSR_WRONG_LIMIT, 15));
      directed.push_back(pinned_row(move_command(0, 1'b1), PULSE_NONE, 1'b1,
                                    STATUS_MOVING, 0, 1'b0));
      directed.push_back(pinned_row(adc_sample(65535, 0), PULSE_OPEN, 1'b1, STATUS_MOVING,
                                    -4096, 1'b0));
      // loop band wider than start band
      directed.push_back(csr_row(CSR_VALVE_KIND, KIND_BUTTERFLY));
      directed.push_back(csr_row(CSR_LOOP_TOL, 4095));
      directed.push_back(pinned_row(move_command(4096, 1'b0), PULSE_NONE, 1'b0,
                                    STATUS_MOVING, 0, 1'b0));
      directed.push_back(item_row(adc_sample(60000, 65535)));

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i]) begin
         if (directed[i].kind == ROW_CSR) begin
            if (i == 0 || directed[i-1].kind == ROW_ITEM) settle_block();
            write_register(directed[i].csr_sel, directed[i].csr_value,
                           i + 1 == directed.size() || directed[i+1].kind != ROW_CSR);
         end else begin
            offer_item(directed[i].item, directed[i].pinned, directed[i].want);
         end
      end

      for (int p = 0; p < PHASE_COUNT; p++) begin
         settle_block();
         case (p)
            0: apply_setup(KIND_BUTTERFLY, START_TOL_RESET, LOOP_TOL_RESET, WRONG_LIMIT_RESET);
            1: apply_setup(KIND_LINEAR, 0, 0, 0);
            2: apply_setup(3, 0, 4095, 15);
            3: apply_setup(KIND_BUTTERFLY, 4095, 4095, 0);
            default: apply_setup(($urandom_range(99) < 15) ? $urandom_range(3, 2)
                                                           : $urandom_range(1),
                                 $urandom_range(500), $urandom_range(400),
                                 $urandom_range(15));
         endcase
         case (p % 4)
            0: begin
               req_gap_pct   = 0;
               rsp_stall_pct = 0;
            end
            1: begin
               req_gap_pct   = 51;
               rsp_stall_pct = 0;
            end
            2: begin
               req_gap_pct   = 0;
               rsp_stall_pct = 51;
            end
            default: begin
               req_gap_pct   = 8;
               rsp_stall_pct = 8;
            end
         endcase
         if (p == 4) holds_asked++;

         phase_end = items_offered + PHASE_ITEMS;
         while (items_offered < phase_end) begin
            roll = $urandom_range(99);
            if (roll < 75) begin
               // one move: command, then samples walking toward the goal
               target = ($urandom_range(99) < 10) ? $urandom_range(8191)
                                                  : $urandom_range(4400);
               pos    = $urandom_range(4400);
               offer_item(move_command(target, 1'($urandom)), 1'b0, free_resp);
               for (int n = 0; n < 24; n++) begin
                  offer_item(sample_at(pos), 1'b0, free_resp);
                  if (valve_mode == MODE_IDLE) break;
                  gap    = target - pos;
                  stride = $urandom_range(((gap < 0) ? -gap : gap) / 3 + 60, 1);
                  if (gap < 0) stride = -stride;
                  if ($urandom_range(99) < 15) pos -= stride / 4 + 1;
                  else pos += stride;
               end
            end else if (roll < 90) begin
               junk.is_sample = 1'($urandom);
               junk.target    = GOAL_BITS'($urandom);
               junk.select    = 1'($urandom);
               junk.wiper     = COUNT_BITS'($urandom);
               junk.supply    = COUNT_BITS'($urandom);
               offer_item(junk, 1'b0, free_resp);
            end else begin
               repeat ($urandom_range(3, 1))
                  offer_item(sample_at($urandom_range(4400)), 1'b0, free_resp);
            end
         end
      end

      settle_block();
      if (mismatch_count == 0 && pending_responses.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
